### rtl/jvs_pkg.sv
// ============================================================================
// jvs_pkg: shared types and constants for the JSON value skipper
// Scan phases, return targets, status codes, register indexes, byte codes
// and the control structs that pass between the scanner, stack and top.
// ============================================================================
package jvs_pkg;

    localparam int MAX_DEPTH_DEFAULT   = 1024;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_INDEX_W         = 2;

    // Reset contents of the word sets
    localparam logic [63:0] WORD_START_LO_RST = 64'd288063250384289792;
    localparam logic [63:0] WORD_START_HI_RST = 64'd576460745995190270;
    localparam logic [63:0] WORD_BODY_LO_RST  = 64'd288063250384289792;
    localparam logic [63:0] WORD_BODY_HI_RST  = 64'd576460745995190270;

    // Byte codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_TOP    = 4'd1,
        PH_KEY    = 4'd2,
        PH_COLON  = 4'd3,
        PH_VALUE  = 4'd4,
        PH_COMMA  = 4'd5,
        PH_STRING = 4'd6,
        PH_ESCAPE = 4'd7,
        PH_WORD   = 4'd8,
        PH_TAIL   = 4'd9,
        PH_IGNORE = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        RET_COLON = 2'd0,
        RET_COMMA = 2'd1,
        RET_TAIL  = 2'd2
    } ret_t;

    typedef enum logic [1:0] {
        ST_SKIPPED  = 2'd0,
        ST_NOTHING  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WORD_START_LO = 2'd0,
        REG_WORD_START_HI = 2'd1,
        REG_WORD_BODY_LO  = 2'd2,
        REG_WORD_BODY_HI  = 2'd3
    } cfg_reg_t;

    // Decision taken on one byte
    typedef struct packed {
        logic   emit;        // result goes out
        logic   overflow;    // result reports depth overflow
        logic   clear;       // return scan state to its idle values
        logic   consume;     // count this byte
        logic   push;        // open a level
        logic   push_kind;   // 1 array, 0 object
        logic   pop;         // close the top level
        phase_t phase_next;
        ret_t   member_next;
        logic   quote_next;
    } scan_step_t;

    // Stack command
    typedef struct packed {
        logic push;
        logic push_kind;
        logic pop;
        logic clear;
    } stack_op_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic in_set(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [7:0] c);
        if (c[7])
            return 1'b0;
        return c[6] ? hi[c[5:0]] : lo[c[5:0]];
    endfunction

    function automatic phase_t after_token(input ret_t r);
        phase_t p;
        case (r)
            RET_COLON: p = PH_COLON;
            RET_COMMA: p = PH_COMMA;
            default:   p = PH_TAIL;
        endcase
        return p;
    endfunction

endpackage

### rtl/jvs_byte_if.sv
// ============================================================================
// jvs_byte_if: text byte channel
// One text byte or an end-of-text mark per transaction.
// ============================================================================
interface jvs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### rtl/jvs_result_if.sv
// ============================================================================
// jvs_result_if: result channel
// Byte count and status of one skipped value per transaction.
// ============================================================================
interface jvs_result_if #(
    parameter int COUNT_W = jvs_pkg::COUNT_WIDTH_DEFAULT
);
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] bytes_consumed;
    logic [1:0]         skip_status;

    modport source (output valid, output bytes_consumed, output skip_status, input ready);
    modport sink   (input valid, input bytes_consumed, input skip_status, output ready);
endinterface

### rtl/jvs_cfg_if.sv
// ============================================================================
// jvs_cfg_if: configuration write channel
// Register index and write data per transaction.
// ============================================================================
interface jvs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [jvs_pkg::CFG_INDEX_W-1:0]  reg_index;
    logic [63:0]                      wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/json_value_skipper.sv
// ============================================================================
// json_value_skipper: lenient JSON value skipper
// Scans text one byte per transaction and reports where one value ends:
// bytes consumed (trailing whitespace included) and a status.
// ============================================================================
//
//  channel  dir  transaction carries
//  -------  ---  ------------------------------------------------
//  cfg      in   reg_index, wr_data (word start/body sets)
//  text     in   text_byte, end_of_text
//  result   out  bytes_consumed, skip_status
//
//  One text transaction is taken every cycle; its result, if any, is on
//  the result port on the following cycle from the output register.
//  The rate is set by the nesting stack: the top bit sits in a register and
//  the entry below it is prefetched from memory ahead of any close.
//  text.ready drops only while a result is held and result.ready is low.
//  Reset clears the scan state at once; no memory clearing pass is run.
//  cfg.ready is always high.
//
module json_value_skipper #(
    parameter int MAX_DEPTH   = jvs_pkg::MAX_DEPTH_DEFAULT,
    parameter int COUNT_WIDTH = jvs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    jvs_cfg_if.sink          cfg,
    jvs_byte_if.sink         text,
    jvs_result_if.source     result
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    // Configuration registers
    logic [63:0] start_lo_reg, start_hi_reg, body_lo_reg, body_hi_reg;

    // Scan state
    jvs_pkg::phase_t        phase_reg;
    jvs_pkg::ret_t          member_reg;
    logic                   quote_reg;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    // Output register
    logic                   res_valid_reg;
    logic [COUNT_WIDTH-1:0] res_count_reg;
    logic [1:0]             res_status_reg;

    logic                   in_fire;
    logic [LVL_W-1:0]       level;
    logic                   top_kind;
    jvs_pkg::scan_step_t    step;
    jvs_pkg::stack_op_t     op;

    // Take a new byte whenever the output register is free or being drained
    assign text.ready = !res_valid_reg || result.ready;
    assign in_fire    = text.valid && text.ready;
    assign cfg.ready  = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_lo_reg <= jvs_pkg::WORD_START_LO_RST;
            start_hi_reg <= jvs_pkg::WORD_START_HI_RST;
            body_lo_reg  <= jvs_pkg::WORD_BODY_LO_RST;
            body_hi_reg  <= jvs_pkg::WORD_BODY_HI_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                jvs_pkg::REG_WORD_START_LO: start_lo_reg <= cfg.wr_data;
                jvs_pkg::REG_WORD_START_HI: start_hi_reg <= cfg.wr_data;
                jvs_pkg::REG_WORD_BODY_LO:  body_lo_reg  <= cfg.wr_data;
                jvs_pkg::REG_WORD_BODY_HI:  body_hi_reg  <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- scanner
    jvs_scan #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scan (
        .c        (text.text_byte),
        .eot      (text.end_of_text),
        .phase    (phase_reg),
        .member   (member_reg),
        .quote    (quote_reg),
        .level    (level),
        .top_kind (top_kind),
        .start_lo (start_lo_reg),
        .start_hi (start_hi_reg),
        .body_lo  (body_lo_reg),
        .body_hi  (body_hi_reg),
        .step     (step)
    );

    // ---------------------------------------------------------------- stack
    // Act on the stack only for an accepted byte
    always_comb
    begin
        op.push      = in_fire && step.push;
        op.push_kind = step.push_kind;
        op.pop       = in_fire && step.pop;
        op.clear     = in_fire && step.clear;
    end

    jvs_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .level    (level),
        .top_kind (top_kind)
    );

    // ---------------------------------------------------------------- counter
    // Saturate at the all-ones count
    always_comb
    begin
        count_next = count_reg;
        if (step.clear)
            count_next = '0;
        else if (step.consume && (count_reg != '1))
            count_next = count_reg + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jvs_pkg::PH_START;
            member_reg <= jvs_pkg::RET_COLON;
            quote_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= step.phase_next;
            count_reg <= count_next;
            if (step.clear)
            begin
                member_reg <= jvs_pkg::RET_COLON;
                quote_reg  <= 1'b0;
            end
            else
            begin
                member_reg <= step.member_next;
                quote_reg  <= step.quote_next;
            end
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (in_fire && step.emit)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // Hold the payload until a new result replaces it
    always_ff @(posedge clk)
    begin
        if (in_fire && step.emit)
        begin
            if (step.overflow)
            begin
                res_count_reg  <= '0;
                res_status_reg <= jvs_pkg::ST_OVERFLOW;
            end
            else
            begin
                res_count_reg  <= count_reg;
                res_status_reg <= (count_reg == '0) ? jvs_pkg::ST_NOTHING
                                                    : jvs_pkg::ST_SKIPPED;
            end
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.bytes_consumed = res_count_reg;
    assign result.skip_status    = res_status_reg;

    // ---------------------------------------------------------------- checks
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && step.emit |=> res_valid_reg)
        else $error("accepted result not registered");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(MAX_DEPTH))
        else $error("nesting level beyond maximum depth");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == jvs_pkg::PH_START || phase_reg == jvs_pkg::PH_IGNORE)
        |-> (count_reg == '0 && level == '0))
        else $error("scan state not cleared between values");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.push && op.pop))
        else $error("stack push and pop together");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop |-> level != '0)
        else $error("pop on empty stack");

endmodule

### rtl/jvs_stack.sv
// ============================================================================
// jvs_stack: nesting kind stack
// Top bit in a register, lower levels in a synchronous memory. The entry
// below the top is prefetched every cycle, with a bypass for a same-cycle
// write to the read address.
// ============================================================================
module jvs_stack #(
    parameter int MAX_DEPTH = jvs_pkg::MAX_DEPTH_DEFAULT,
    localparam int LVL_W    = $clog2(MAX_DEPTH + 1),
    localparam int ADDR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  jvs_pkg::stack_op_t op,
    output logic [LVL_W-1:0]   level,
    output logic               top_kind
);

    logic              mem [MAX_DEPTH];
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              top_reg, top_next;
    logic              rd_q_reg;
    logic              byp_valid_reg;
    logic              byp_data_reg;
    logic              below;
    logic              wr_en;
    logic [LVL_W-1:0]  wr_lvl, rd_lvl;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign below   = byp_valid_reg ? byp_data_reg : rd_q_reg;
    assign wr_en   = op.push && (level_reg != '0);
    assign wr_lvl  = level_reg - LVL_W'(1);
    assign wr_addr = wr_lvl[ADDR_W-1:0];
    assign rd_lvl  = level_next - LVL_W'(2);
    assign rd_addr = rd_lvl[ADDR_W-1:0];

    always_comb
    begin
        level_next = level_reg;
        top_next   = top_reg;
        if (op.clear)
        begin
            level_next = '0;
        end
        else if (op.push)
        begin
            level_next = level_reg + LVL_W'(1);
            top_next   = op.push_kind;
        end
        else if (op.pop)
        begin
            level_next = level_reg - LVL_W'(1);
            top_next   = below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            byp_valid_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= top_reg;
        rd_q_reg <= mem[rd_addr];
    end

    assign level    = level_reg;
    assign top_kind = top_reg;

endmodule

### rtl/jvs_scan.sv
// ============================================================================
// jvs_scan: per-byte scanner decision
// Walks the chain of phases that one byte may pass through and returns
// the counting, stack, result and phase decisions for that byte.
// ============================================================================
module jvs_scan #(
    parameter int MAX_DEPTH = jvs_pkg::MAX_DEPTH_DEFAULT,
    localparam int LVL_W    = $clog2(MAX_DEPTH + 1)
) (
    input  logic [7:0]           c,
    input  logic                 eot,
    input  jvs_pkg::phase_t      phase,
    input  jvs_pkg::ret_t        member,
    input  logic                 quote,
    input  logic [LVL_W-1:0]     level,
    input  logic                 top_kind,
    input  logic [63:0]          start_lo,
    input  logic [63:0]          start_hi,
    input  logic [63:0]          body_lo,
    input  logic [63:0]          body_hi,
    output jvs_pkg::scan_step_t  step
);

    jvs_pkg::phase_t ph;
    logic done;
    logic top_seen;
    logic white, is_open, is_close, is_quote, start_hit, body_hit, full;
    logic [7:0] close_quote;

    assign white      = jvs_pkg::is_white(c);
    assign is_open    = (c == jvs_pkg::CH_LBRACK) || (c == jvs_pkg::CH_LBRACE);
    assign is_close   = (c == jvs_pkg::CH_RBRACK) || (c == jvs_pkg::CH_RBRACE);
    assign is_quote   = (c == jvs_pkg::CH_DQUOTE) || (c == jvs_pkg::CH_SQUOTE);
    assign start_hit  = jvs_pkg::in_set(start_lo, start_hi, c);
    assign body_hit   = jvs_pkg::in_set(body_lo, body_hi, c);
    assign full       = (level == LVL_W'(MAX_DEPTH));
    assign close_quote = quote ? jvs_pkg::CH_SQUOTE : jvs_pkg::CH_DQUOTE;

    always_comb
    begin
        step             = '0;
        step.member_next = member;
        step.quote_next  = quote;
        ph               = phase;
        done             = 1'b0;
        top_seen         = 1'b0;

        if (eot)
        begin
            // end of text: drop the ignore state or report what was scanned
            step.clear = 1'b1;
            step.emit  = (phase != jvs_pkg::PH_IGNORE);
            ph         = jvs_pkg::PH_START;
        end
        else if (phase != jvs_pkg::PH_IGNORE)
        begin
            case (phase)
                jvs_pkg::PH_START:
                begin
                    if (is_close)
                    begin
                        // a close with no open level ends the scan at once
                        step.emit = 1'b1;
                    end
                    else if (is_open && !full)
                    begin
                        step.push      = 1'b1;
                        step.push_kind = (c == jvs_pkg::CH_LBRACK);
                        step.consume   = 1'b1;
                        ph             = jvs_pkg::PH_COMMA;
                    end
                    else if (is_open)
                    begin
                        step.emit     = 1'b1;
                        step.overflow = 1'b1;
                    end
                    else if (is_quote)
                    begin
                        step.quote_next  = (c == jvs_pkg::CH_SQUOTE);
                        step.member_next = jvs_pkg::RET_TAIL;
                        step.consume     = 1'b1;
                        ph               = jvs_pkg::PH_STRING;
                    end
                    else if (start_hit)
                    begin
                        step.member_next = jvs_pkg::RET_TAIL;
                        step.consume     = 1'b1;
                        ph               = jvs_pkg::PH_WORD;
                    end
                    else
                    begin
                        step.emit = 1'b1;
                    end
                end
                jvs_pkg::PH_STRING:
                begin
                    step.consume = 1'b1;
                    if (c == close_quote)
                        ph = jvs_pkg::after_token(member);
                    else if (c == jvs_pkg::CH_BSLASH)
                        ph = jvs_pkg::PH_ESCAPE;
                end
                jvs_pkg::PH_ESCAPE:
                begin
                    step.consume = 1'b1;
                    ph           = jvs_pkg::PH_STRING;
                end
                default:
                begin
                    // word body
                    if (ph == jvs_pkg::PH_WORD)
                    begin
                        if (body_hit)
                        begin
                            step.consume = 1'b1;
                            done         = 1'b1;
                        end
                        else
                            ph = jvs_pkg::after_token(member);
                    end
                    // the member chain may wrap round once; the member start
                    // is taken only on the first visit
                    for (int lap = 0; lap < 2; lap++)
                    begin
                        // start of a member: close, whitespace or next item
                        if (!done && ph == jvs_pkg::PH_TOP)
                        begin
                            done = 1'b1;
                            if (white)
                                step.consume = 1'b1;
                            else if (top_seen || level == '0)
                                step.emit = 1'b1;
                            else
                            begin
                                top_seen = 1'b1;
                                if (is_close)
                                begin
                                    if ((c == jvs_pkg::CH_RBRACK) != top_kind)
                                        step.emit = 1'b1;
                                    else
                                    begin
                                        step.consume = 1'b1;
                                        step.pop     = 1'b1;
                                        if (level == LVL_W'(1))
                                            ph = jvs_pkg::PH_TAIL;
                                    end
                                end
                                else
                                begin
                                    done = 1'b0;
                                    ph   = top_kind ? jvs_pkg::PH_VALUE : jvs_pkg::PH_KEY;
                                end
                            end
                        end
                        // object key
                        if (!done && ph == jvs_pkg::PH_KEY)
                        begin
                            if (is_quote)
                            begin
                                step.quote_next  = (c == jvs_pkg::CH_SQUOTE);
                                step.member_next = jvs_pkg::RET_COLON;
                                step.consume     = 1'b1;
                                ph               = jvs_pkg::PH_STRING;
                                done             = 1'b1;
                            end
                            else if (start_hit)
                            begin
                                step.member_next = jvs_pkg::RET_COLON;
                                step.consume     = 1'b1;
                                ph               = jvs_pkg::PH_WORD;
                                done             = 1'b1;
                            end
                            else
                                ph = jvs_pkg::PH_COLON;
                        end
                        // optional colon
                        if (!done && ph == jvs_pkg::PH_COLON)
                        begin
                            if (white)
                            begin
                                step.consume = 1'b1;
                                done         = 1'b1;
                            end
                            else if (c == jvs_pkg::CH_COLON)
                            begin
                                step.consume = 1'b1;
                                ph           = jvs_pkg::PH_VALUE;
                                done         = 1'b1;
                            end
                            else
                                ph = jvs_pkg::PH_VALUE;
                        end
                        // member value
                        if (!done && ph == jvs_pkg::PH_VALUE)
                        begin
                            done = 1'b1;
                            if (white)
                                step.consume = 1'b1;
                            else if (is_open && !full)
                            begin
                                step.push      = 1'b1;
                                step.push_kind = (c == jvs_pkg::CH_LBRACK);
                                step.consume   = 1'b1;
                                ph             = jvs_pkg::PH_COMMA;
                            end
                            else if (is_open)
                            begin
                                step.emit     = 1'b1;
                                step.overflow = 1'b1;
                            end
                            else if (is_quote)
                            begin
                                step.quote_next  = (c == jvs_pkg::CH_SQUOTE);
                                step.member_next = jvs_pkg::RET_COMMA;
                                step.consume     = 1'b1;
                                ph               = jvs_pkg::PH_STRING;
                            end
                            else if (start_hit)
                            begin
                                step.member_next = jvs_pkg::RET_COMMA;
                                step.consume     = 1'b1;
                                ph               = jvs_pkg::PH_WORD;
                            end
                            else
                            begin
                                done = 1'b0;
                                ph   = jvs_pkg::PH_COMMA;
                            end
                        end
                        // optional comma
                        if (!done && ph == jvs_pkg::PH_COMMA)
                        begin
                            done = 1'b1;
                            if (white)
                                step.consume = 1'b1;
                            else if (c == jvs_pkg::CH_COMMA)
                            begin
                                step.consume = 1'b1;
                                ph           = jvs_pkg::PH_TOP;
                            end
                            else
                            begin
                                done = 1'b0;
                                ph   = jvs_pkg::PH_TOP;
                            end
                        end
                    end
                    // trailing whitespace; a second pass through the member
                    // start and unknown phases end the scan
                    if (!done)
                    begin
                        if (ph == jvs_pkg::PH_TAIL && white)
                            step.consume = 1'b1;
                        else
                            step.emit = 1'b1;
                    end
                end
            endcase
            if (step.emit)
            begin
                step.clear = 1'b1;
                ph         = jvs_pkg::PH_IGNORE;
            end
        end
        step.phase_next = ph;
    end

endmodule
